/* src/tsd_pkg.sv */
// Package for the thermostat schedule decider: field widths, register
// indexes, mode codes, word and configuration structs, window function.
// No dependencies.
package tsd_pkg;

	localparam int TEMP_W     = 12;
	localparam int MIN_W      = 11;
	localparam int CFG_DATA_W = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int WEEKEND_PERIODS = 2;
	localparam int MAX_WEEKDAY_PERIODS = 4;
	localparam int MINUTES_PER_HOUR = 60;

	localparam logic [2:0] DAY_SAT = 3'd6;
	localparam logic [2:0] DAY_SUN = 3'd7;

	typedef enum logic [1:0] {
		MODE_OFF    = 2'd0,
		MODE_WATER  = 2'd1,
		MODE_HEAT   = 2'd2,
		MODE_MANUAL = 2'd3
	} tsd_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROGRAM_MODE     = 3'd0,
		REG_WATER_SETPOINT   = 3'd1,
		REG_WATER_CHECK_TEMP = 3'd2,
		REG_WATER_WINDOW     = 3'd3,
		REG_MANUAL_SETPOINT  = 3'd4,
		REG_WEEKDAY_STARTS   = 3'd5,
		REG_WEEKDAY_TEMPS    = 3'd6,
		REG_WEEKEND_SCHEDULE = 3'd7
	} tsd_reg_t;

	typedef struct packed {
		tsd_mode_t                 program_mode;
		logic signed [TEMP_W-1:0]  water_setpoint;
		logic                      water_check_temp;
		logic [2*MIN_W-1:0]        water_window;
		logic signed [TEMP_W-1:0]  manual_setpoint;
		logic [4*MIN_W-1:0]        weekday_starts;
		logic [4*TEMP_W-1:0]       weekday_temps;
		logic [2*MIN_W+2*TEMP_W-1:0] weekend_schedule;
	} tsd_cfg_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] tank_temp;
		logic signed [TEMP_W-1:0] room_temp;
		logic [2:0]               weekday;
		logic [4:0]               hour;
		logic [5:0]               minute;
	} tsd_sample_t;

	typedef struct packed {
		logic                     heat_on;
		logic signed [TEMP_W-1:0] active_setpoint;
		logic                     setpoint_valid;
	} tsd_result_t;

	// start < end: [start, end); start > end: wraps, end minute included;
	// start == end: never active
	function automatic logic win_active(input logic [MIN_W-1:0] t,
		input logic [MIN_W-1:0] s, input logic [MIN_W-1:0] e);
		logic r;
		if (s < e) begin
			r = (t >= s) && (t < e);
		end else if (s > e) begin
			r = !((t > e) && (t < s));
		end else begin
			r = 1'b0;
		end
		return r;
	endfunction

endpackage

/* src/tsd_if.sv */
// Valid/ready channel interfaces for sample and result words.
// Depends on tsd_pkg for field widths.
interface tsd_sample_if;
	logic                              valid;
	logic                              ready;
	logic signed [tsd_pkg::TEMP_W-1:0] tank_temp;
	logic signed [tsd_pkg::TEMP_W-1:0] room_temp;
	logic [2:0]                        weekday;
	logic [4:0]                        hour;
	logic [5:0]                        minute;

	modport source(output valid, tank_temp, room_temp, weekday, hour, minute,
		input ready);
	modport sink(input valid, tank_temp, room_temp, weekday, hour, minute,
		output ready);
endinterface

interface tsd_result_if;
	logic                              valid;
	logic                              ready;
	logic                              heat_on;
	logic signed [tsd_pkg::TEMP_W-1:0] active_setpoint;
	logic                              setpoint_valid;

	modport source(output valid, heat_on, active_setpoint, setpoint_valid,
		input ready);
	modport sink(input valid, heat_on, active_setpoint, setpoint_valid,
		output ready);
endinterface

/* src/tsd_cfg_regs.sv */
// Configuration register file written through the plain write port.
// Depends on tsd_pkg.
module tsd_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tsd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tsd_pkg::CFG_DATA_W-1:0]  cfg_data,
	output tsd_pkg::tsd_cfg_t               cfg
);

	tsd_pkg::tsd_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (tsd_pkg::tsd_reg_t'(cfg_index))
				tsd_pkg::REG_PROGRAM_MODE: begin
					cfg_q.program_mode <= tsd_pkg::tsd_mode_t'(cfg_data[1:0]);
				end
				tsd_pkg::REG_WATER_SETPOINT: begin
					cfg_q.water_setpoint <= cfg_data[tsd_pkg::TEMP_W-1:0];
				end
				tsd_pkg::REG_WATER_CHECK_TEMP: begin
					cfg_q.water_check_temp <= cfg_data[0];
				end
				tsd_pkg::REG_WATER_WINDOW: begin
					cfg_q.water_window <= cfg_data[2*tsd_pkg::MIN_W-1:0];
				end
				tsd_pkg::REG_MANUAL_SETPOINT: begin
					cfg_q.manual_setpoint <= cfg_data[tsd_pkg::TEMP_W-1:0];
				end
				tsd_pkg::REG_WEEKDAY_STARTS: begin
					cfg_q.weekday_starts <= cfg_data[4*tsd_pkg::MIN_W-1:0];
				end
				tsd_pkg::REG_WEEKDAY_TEMPS: begin
					cfg_q.weekday_temps <= cfg_data[4*tsd_pkg::TEMP_W-1:0];
				end
				tsd_pkg::REG_WEEKEND_SCHEDULE: begin
					cfg_q.weekend_schedule <=
						cfg_data[2*tsd_pkg::MIN_W+2*tsd_pkg::TEMP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* src/tsd_decide.sv */
// Combinational heat decision for one registered sample.
// Depends on tsd_pkg.
module tsd_decide #(
	parameter int WEEKDAY_PERIODS = 4
) (
	input  tsd_pkg::tsd_cfg_t    cfg,
	input  tsd_pkg::tsd_sample_t smp,
	output tsd_pkg::tsd_result_t res
);

	localparam int MW = tsd_pkg::MIN_W;
	localparam int TW = tsd_pkg::TEMP_W;
	localparam int WE = tsd_pkg::WEEKEND_PERIODS;

	logic [MW-1:0]          t;
	logic                   weekend;
	logic [WEEKDAY_PERIODS-1:0] wd_match;
	logic signed [TW-1:0]   wd_temp [WEEKDAY_PERIODS];
	logic [WE-1:0]          we_match;
	logic signed [TW-1:0]   we_temp [WE];
	logic                   heat_hit;
	logic                   heat_valid;
	logic signed [TW-1:0]   heat_sp;

	assign t = MW'(smp.hour) * MW'(tsd_pkg::MINUTES_PER_HOUR) + MW'(smp.minute);
	assign weekend = (smp.weekday == tsd_pkg::DAY_SAT) ||
		(smp.weekday == tsd_pkg::DAY_SUN);

	always_comb begin
		for (int k = 0; k < WEEKDAY_PERIODS; k++) begin
			wd_match[k] = tsd_pkg::win_active(t, cfg.weekday_starts[MW*k +: MW],
				cfg.weekday_starts[MW*((k == WEEKDAY_PERIODS-1) ? 0 : k+1) +: MW]);
			wd_temp[k] = cfg.weekday_temps[TW*k +: TW];
		end
		for (int k = 0; k < WE; k++) begin
			we_match[k] = tsd_pkg::win_active(t, cfg.weekend_schedule[MW*k +: MW],
				cfg.weekend_schedule[MW*((k == WE-1) ? 0 : k+1) +: MW]);
			we_temp[k] = cfg.weekend_schedule[WE*MW+TW*k +: TW];
		end
	end

	// walk periods in order; stop at first match above the tank temperature
	always_comb begin
		heat_hit   = 1'b0;
		heat_valid = 1'b0;
		heat_sp    = '0;
		if (weekend) begin
			for (int k = 0; k < WE; k++) begin
				if (we_match[k] && !heat_hit) begin
					heat_sp    = we_temp[k];
					heat_valid = 1'b1;
					heat_hit   = smp.tank_temp < we_temp[k];
				end
			end
		end else begin
			for (int k = 0; k < WEEKDAY_PERIODS; k++) begin
				if (wd_match[k] && !heat_hit) begin
					heat_sp    = wd_temp[k];
					heat_valid = 1'b1;
					heat_hit   = smp.tank_temp < wd_temp[k];
				end
			end
		end
	end

	always_comb begin
		res = '0;
		case (cfg.program_mode)
			tsd_pkg::MODE_WATER: begin
				res.heat_on = tsd_pkg::win_active(t, cfg.water_window[MW-1:0],
					cfg.water_window[2*MW-1:MW]) &&
					(!cfg.water_check_temp || (smp.tank_temp < cfg.water_setpoint));
			end
			tsd_pkg::MODE_HEAT: begin
				res.heat_on         = heat_hit;
				res.active_setpoint = heat_sp;
				res.setpoint_valid  = heat_valid;
			end
			tsd_pkg::MODE_MANUAL: begin
				res.heat_on = smp.room_temp < cfg.manual_setpoint;
			end
			default: begin
				res = '0;
			end
		endcase
	end

endmodule

/* src/thermostat_schedule_decider_unit.sv */
// Thermostat schedule decider. Takes one sample word per clock and returns
// one result word for each accepted sample: the sample is registered, the
// heat decision is worked out in one pass of logic from the configuration
// registers, and the result is held in an output register. The only stall is
// back pressure on the result channel; with the result taken every cycle the
// block sustains one word per cycle. Write configuration only while idle.
// Depends on tsd_pkg, tsd_if, tsd_cfg_regs and tsd_decide.
module thermostat_schedule_decider_unit #(
	parameter int WEEKDAY_PERIODS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tsd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tsd_pkg::CFG_DATA_W-1:0]  cfg_data,
	tsd_sample_if.sink                      sample,
	tsd_result_if.source                    result
);

	tsd_pkg::tsd_cfg_t    cfg;
	tsd_pkg::tsd_sample_t sample_s1;
	tsd_pkg::tsd_result_t dec;
	tsd_pkg::tsd_result_t result_s2;
	logic                 valid_s1;
	logic                 valid_s2;
	logic                 adv_s2;
	logic                 ready_in;

	tsd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tsd_decide #(
		.WEEKDAY_PERIODS (WEEKDAY_PERIODS)
	) u_decide (
		.cfg (cfg),
		.smp (sample_s1),
		.res (dec)
	);

	assign adv_s2   = !valid_s2 || result.ready;
	assign ready_in = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_in) begin
				valid_s1 <= sample.valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && ready_in) begin
			sample_s1.tank_temp <= sample.tank_temp;
			sample_s1.room_temp <= sample.room_temp;
			sample_s1.weekday   <= sample.weekday;
			sample_s1.hour      <= sample.hour;
			sample_s1.minute    <= sample.minute;
		end
		if (valid_s1 && adv_s2) begin
			result_s2 <= dec;
		end
	end

	assign sample.ready           = ready_in;
	assign result.valid           = valid_s2;
	assign result.heat_on         = result_s2.heat_on;
	assign result.active_setpoint = result_s2.active_setpoint;
	assign result.setpoint_valid  = result_s2.setpoint_valid;

endmodule

/* src/tsd_checker.sv */
// Port-level checks for the thermostat schedule decider, bound to the top.
// Depends on thermostat_schedule_decider_unit and tsd_pkg.
module tsd_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic                              heat_on,
	input logic signed [tsd_pkg::TEMP_W-1:0] active_setpoint,
	input logic                              setpoint_valid
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
		$stable({heat_on, active_setpoint, setpoint_valid}))
		else $error("result word changed while stalled");

	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("sample refused without result back pressure");

	a_sp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !setpoint_valid |-> active_setpoint == '0)
		else $error("setpoint nonzero without a matched period");

endmodule

bind thermostat_schedule_decider_unit tsd_checker u_tsd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_ready        (sample.ready),
	.out_valid       (result.valid),
	.out_ready       (result.ready),
	.heat_on         (result.heat_on),
	.active_setpoint (result.active_setpoint),
	.setpoint_valid  (result.setpoint_valid)
);

/* verif/tb.sv */
// Testbench for thermostat_schedule_decider_unit: directed and random sample words
// across several register settings, results checked against an in-bench predictor.
// Depends on tsd_pkg, tsd_if and the unit itself.
module tb;
	import tsd_pkg::*;

	localparam int WEEKDAY_PERIODS = 4;

	class heat_decision_board;
		tsd_cfg_t    cfg;
		tsd_result_t pending[$];
		int          mismatch_count;

		function new();
			cfg = '0;
			mismatch_count = 0;
		endfunction

		static function bit in_window(int t, int s, int e);
			if (s < e) begin
				return (t >= s) && (t < e);
			end
			if (s > e) begin
				return !((t > e) && (t < s));
			end
			return 1'b0;
		endfunction

		function tsd_result_t decide_heat(tsd_sample_t s);
			tsd_result_t             r;
			int                      t;
			int                      count;
			int                      nk;
			bit                      weekend;
			logic [MIN_W-1:0]        ps;
			logic [MIN_W-1:0]        pe;
			logic signed [TEMP_W-1:0] temp;
			r = '0;
			t = int'(s.hour) * MINUTES_PER_HOUR + int'(s.minute);
			case (cfg.program_mode)
				MODE_WATER: begin
					if (in_window(t, cfg.water_window[MIN_W-1:0],
						cfg.water_window[2*MIN_W-1:MIN_W]) &&
						(!cfg.water_check_temp || s.tank_temp < cfg.water_setpoint))
						r.heat_on = 1'b1;
				end
				MODE_HEAT: begin
					weekend = (s.weekday == DAY_SAT) || (s.weekday == DAY_SUN);
					count = weekend ? WEEKEND_PERIODS : WEEKDAY_PERIODS;
					for (int k = 0; k < count && !r.heat_on; k++) begin
						nk = (k + 1) % count;
						if (weekend) begin
							ps = cfg.weekend_schedule[MIN_W*k +: MIN_W];
							pe = cfg.weekend_schedule[MIN_W*nk +: MIN_W];
							temp = cfg.weekend_schedule[2*MIN_W + TEMP_W*k +: TEMP_W];
						end else begin
							ps = cfg.weekday_starts[MIN_W*k +: MIN_W];
							pe = cfg.weekday_starts[MIN_W*nk +: MIN_W];
							temp = cfg.weekday_temps[TEMP_W*k +: TEMP_W];
						end
						if (in_window(t, ps, pe)) begin
							r.active_setpoint = temp;
							r.setpoint_valid = 1'b1;
							if (s.tank_temp < temp)
								r.heat_on = 1'b1;
						end
					end
				end
				MODE_MANUAL: begin
					if (s.room_temp < cfg.manual_setpoint)
						r.heat_on = 1'b1;
				end
				default: begin
				end
			endcase
			return r;
		endfunction

		function void note_sample(tsd_sample_t s);
			pending.push_back(decide_heat(s));
		endfunction

		function int outstanding();
			return pending.size();
		endfunction

		task report(string what);
			mismatch_count++;
			$display("%0t: %s", $time, what);
		endtask

		task check_result(tsd_result_t got);
			tsd_result_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result word: heat %0b sp %0d valid %0b",
					got.heat_on, got.active_setpoint, got.setpoint_valid));
				return;
			end
			want = pending.pop_front();
			if (got.heat_on !== want.heat_on)
				report($sformatf("heat_on %0b, want %0b", got.heat_on, want.heat_on));
			if (got.active_setpoint !== want.active_setpoint)
				report($sformatf("active_setpoint %0d, want %0d",
					got.active_setpoint, want.active_setpoint));
			if (got.setpoint_valid !== want.setpoint_valid)
				report($sformatf("setpoint_valid %0b, want %0b",
					got.setpoint_valid, want.setpoint_valid));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	bit                    no_idle;
	bit                    sender_idles;

	tsd_sample_if sample_ch();
	tsd_result_if result_ch();

	heat_decision_board sb = new();

	thermostat_schedule_decider_unit #(
		.WEEKDAY_PERIODS(WEEKDAY_PERIODS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.sample   (sample_ch),
		.result   (result_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	always @(posedge clk) begin
		tsd_sample_t s;
		tsd_result_t r;
		if (sample_ch.valid && sample_ch.ready) begin
			s.tank_temp = sample_ch.tank_temp;
			s.room_temp = sample_ch.room_temp;
			s.weekday   = sample_ch.weekday;
			s.hour      = sample_ch.hour;
			s.minute    = sample_ch.minute;
			sb.note_sample(s);
		end
		if (result_ch.valid && result_ch.ready) begin
			r.heat_on         = result_ch.heat_on;
			r.active_setpoint = result_ch.active_setpoint;
			r.setpoint_valid  = result_ch.setpoint_valid;
			sb.check_result(r);
		end
	end

	// result side back pressure
	initial begin
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!no_idle && $urandom_range(0, 2) == 0) begin
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	function automatic tsd_sample_t mk_sample(int tank, int room, int day, int hr, int mn);
		tsd_sample_t s;
		s.tank_temp = TEMP_W'(tank);
		s.room_temp = TEMP_W'(room);
		s.weekday   = 3'(day);
		s.hour      = 5'(hr);
		s.minute    = 6'(mn);
		return s;
	endfunction

	function automatic logic [MIN_W-1:0] random_minute();
		if ($urandom_range(0, 9) == 0)
			return MIN_W'($urandom_range(0, 2047));
		return MIN_W'($urandom_range(0, 1439));
	endfunction

	// temperatures close to a configured setpoint so comparisons flip both ways
	function automatic logic [TEMP_W-1:0] near_setpoint();
		logic [TEMP_W-1:0] base;
		case ($urandom_range(0, 3))
			0: base = sb.cfg.water_setpoint;
			1: base = sb.cfg.manual_setpoint;
			2: base = sb.cfg.weekday_temps[TEMP_W*$urandom_range(0, 3) +: TEMP_W];
			default: base = sb.cfg.weekend_schedule[2*MIN_W + TEMP_W*$urandom_range(0, 1)
				+: TEMP_W];
		endcase
		return base + TEMP_W'($urandom_range(0, 2)) - TEMP_W'(1);
	endfunction

	function automatic tsd_sample_t random_sample();
		tsd_sample_t s;
		s.tank_temp = ($urandom_range(0, 1) == 0) ? TEMP_W'($urandom) : near_setpoint();
		s.room_temp = ($urandom_range(0, 1) == 0) ? TEMP_W'($urandom) : near_setpoint();
		s.weekday = 3'($urandom_range(0, 7));
		if ($urandom_range(0, 6) == 0) begin
			s.hour   = 5'($urandom_range(0, 31));
			s.minute = 6'($urandom_range(0, 63));
		end else begin
			s.hour   = 5'($urandom_range(0, 23));
			s.minute = 6'($urandom_range(0, 59));
		end
		return s;
	endfunction

	// style 0: random, 1: all minimum, 2: all bits set
	function automatic tsd_cfg_t random_config(tsd_mode_t m, int style);
		tsd_cfg_t c;
		int       mins[$];
		logic [MIN_W-1:0] ws;
		if (style == 1) begin
			c = '0;
			c.water_setpoint  = 12'h800;
			c.manual_setpoint = 12'h800;
			c.weekday_temps   = {4{12'h800}};
			c.weekend_schedule[2*MIN_W +: 2*TEMP_W] = {2{12'h800}};
		end else if (style == 2) begin
			c = '1;
		end else begin
			c.water_setpoint   = TEMP_W'($urandom);
			c.water_check_temp = 1'($urandom_range(0, 1));
			ws = random_minute();
			c.water_window = {($urandom_range(0, 9) == 0) ? ws : random_minute(), ws};
			c.manual_setpoint  = TEMP_W'($urandom);
			c.weekday_temps    = {16'($urandom), 32'($urandom)};
			repeat (4) mins.push_back(int'(random_minute()));
			if ($urandom_range(0, 3) != 0)
				mins.sort();
			c.weekday_starts = {MIN_W'(mins[3]), MIN_W'(mins[2]), MIN_W'(mins[1]),
				MIN_W'(mins[0])};
			mins.delete();
			repeat (2) mins.push_back(int'(random_minute()));
			if ($urandom_range(0, 3) != 0)
				mins.sort();
			c.weekend_schedule = {TEMP_W'($urandom), TEMP_W'($urandom), MIN_W'(mins[1]),
				MIN_W'(mins[0])};
		end
		c.program_mode = m;
		return c;
	endfunction

	task automatic load_config(tsd_cfg_t c);
		tsd_reg_t              idx;
		logic [CFG_DATA_W-1:0] v;
		logic [CFG_DATA_W-1:0] mask;
		logic [CFG_DATA_W-1:0] junk;
		int                    w;
		for (int i = 0; i < 8; i++) begin
			idx = tsd_reg_t'(i);
			v = '0;
			case (idx)
				REG_PROGRAM_MODE:     begin v = c.program_mode;     w = 2;  end
				REG_WATER_SETPOINT:   begin v = c.water_setpoint;   w = 12; end
				REG_WATER_CHECK_TEMP: begin v = c.water_check_temp; w = 1;  end
				REG_WATER_WINDOW:     begin v = c.water_window;     w = 22; end
				REG_MANUAL_SETPOINT:  begin v = c.manual_setpoint;  w = 12; end
				REG_WEEKDAY_STARTS:   begin v = c.weekday_starts;   w = 44; end
				REG_WEEKDAY_TEMPS:    begin v = c.weekday_temps;    w = 48; end
				default:              begin v = c.weekend_schedule; w = 46; end
			endcase
			mask = (w == CFG_DATA_W) ? '1 : ((CFG_DATA_W'(1) << w) - 1);
			junk = ($urandom_range(0, 3) == 0) ? {16'($urandom), 32'($urandom)} : '0;
			cfg_we    <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= (junk & ~mask) | (v & mask);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
		sb.cfg = c;
	endtask

	task automatic send_sample(tsd_sample_t s);
		sample_ch.valid     <= 1'b1;
		sample_ch.tank_temp <= s.tank_temp;
		sample_ch.room_temp <= s.room_temp;
		sample_ch.weekday   <= s.weekday;
		sample_ch.hour      <= s.hour;
		sample_ch.minute    <= s.minute;
		@(posedge clk);
		while (sample_ch.ready !== 1'b1) @(posedge clk);
	endtask

	task automatic pause_sender(int n);
		sample_ch.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_drained();
		int n;
		n = 0;
		sample_ch.valid <= 1'b0;
		do begin
			@(posedge clk);
			n++;
		end while (sb.outstanding() != 0 && n < 5000);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_random(int count);
		repeat (count) begin
			send_sample(random_sample());
			if (!no_idle && sender_idles && $urandom_range(0, 3) == 0)
				pause_sender($urandom_range(1, 16));
		end
	endtask

	initial begin
		tsd_cfg_t  c;
		tsd_mode_t modes[11];
		int        styles[11];
		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_index           <= REG_PROGRAM_MODE;
		cfg_data            <= '0;
		sample_ch.valid     <= 1'b0;
		sample_ch.tank_temp <= '0;
		sample_ch.room_temp <= '0;
		sample_ch.weekday   <= '0;
		sample_ch.hour      <= '0;
		sample_ch.minute    <= '0;
		no_idle      = 1'b0;
		sender_idles = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at reset: off
		send_sample(mk_sample(2047, -2048, 7, 31, 63));
		send_sample(mk_sample(-2048, 2047, 0, 0, 0));
		wait_drained();

		// hot water, window wraps midnight, tank check on
		c = '0;
		c.program_mode     = MODE_WATER;
		c.water_setpoint   = 12'd500;
		c.water_check_temp = 1'b1;
		c.water_window     = {11'd120, 11'd1380};
		load_config(c);
		send_sample(mk_sample(499, 0, 1, 2, 0));
		send_sample(mk_sample(0, 0, 1, 2, 1));
		send_sample(mk_sample(500, 0, 2, 23, 0));
		send_sample(mk_sample(0, 0, 3, 22, 59));
		send_sample(mk_sample(-2048, 0, 4, 0, 0));
		wait_drained();

		// plain window, no tank check
		c.water_check_temp = 1'b0;
		c.water_window     = {11'd480, 11'd360};
		load_config(c);
		send_sample(mk_sample(2047, 0, 1, 5, 59));
		send_sample(mk_sample(2047, 0, 1, 6, 0));
		send_sample(mk_sample(2047, 0, 1, 7, 59));
		send_sample(mk_sample(2047, 0, 1, 8, 0));
		wait_drained();

		// empty window
		c.water_window = {11'd600, 11'd600};
		load_config(c);
		send_sample(mk_sample(-2048, 0, 5, 10, 0));
		wait_drained();

		// scheduled heating
		c.program_mode     = MODE_HEAT;
		c.weekday_starts   = {11'd1320, 11'd1020, 11'd480, 11'd360};
		c.weekday_temps    = {12'd150, 12'd2047, 12'h800, 12'd210};
		c.weekend_schedule = {12'hFFB, 12'd200, 11'd1380, 11'd420};
		load_config(c);
		send_sample(mk_sample(100, 0, 1, 6, 40));
		send_sample(mk_sample(0, 0, 3, 8, 20));
		send_sample(mk_sample(300, 0, 2, 6, 0));
		send_sample(mk_sample(2046, 0, 0, 18, 20));
		send_sample(mk_sample(199, 0, 6, 8, 20));
		send_sample(mk_sample(-6, 0, 7, 23, 20));
		send_sample(mk_sample(-5, 0, 6, 23, 0));
		wait_drained();

		// all period starts equal: nothing matches
		c.weekday_starts = '0;
		load_config(c);
		send_sample(mk_sample(-2048, 0, 2, 12, 0));
		wait_drained();

		// manual
		c.program_mode    = MODE_MANUAL;
		c.manual_setpoint = 12'd0;
		load_config(c);
		send_sample(mk_sample(0, -1, 4, 9, 0));
		send_sample(mk_sample(0, 0, 4, 9, 0));
		wait_drained();

		modes = '{MODE_HEAT, MODE_WATER, MODE_MANUAL, MODE_OFF, MODE_HEAT, MODE_WATER,
			MODE_HEAT, MODE_MANUAL, MODE_HEAT, MODE_WATER, MODE_HEAT};
		styles = '{0, 1, 0, 0, 2, 0, 0, 2, 1, 0, 0};
		for (int p = 0; p < 11; p++) begin
			load_config(random_config(modes[p], styles[p]));
			sender_idles = ($urandom_range(0, 3) != 0);
			if (p == 10)
				no_idle = 1'b1;
			send_random(50);
			if (p == 5)
				wait_drained();
			send_random(50);
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (sb.outstanding() != 0)
			sb.report($sformatf("%0d result words never arrived", sb.outstanding()));
		if (sb.mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

/* sim.f */
src/tsd_pkg.sv
src/tsd_if.sv
src/tsd_cfg_regs.sv
src/tsd_decide.sv
src/thermostat_schedule_decider_unit.sv
src/tsd_checker.sv
verif/tb.sv
